FILE: rtl/slnw_pkg.sv
`default_nettype none

package slnw_pkg;

    // Display geometry and number format.
    localparam int DigitCount = 6;
    localparam int FracBits   = 16;
    localparam int DotCount   = DigitCount - 1;
    localparam int ComCount   = 4;

    // Field widths of the item and result channels.
    localparam int ModeW  = 3;
    localparam int ValueW = 37;
    localparam int DecW   = 3;
    localparam int PosW   = 3;
    localparam int DigW   = 4;
    localparam int WordW  = 26;

    // Number path widths. PowW holds the largest power of ten that decimals can select.
    localparam int PowW         = 24;
    localparam int MagW         = ValueW;
    localparam int LoW          = (MagW + 1) / 2;
    localparam int HiW          = MagW - LoW;
    localparam int ProdW        = MagW + PowW;
    localparam int ScaledW      = ProdW - FracBits;
    localparam int BitsPerStage = 8;
    localparam int DabStages    = (ScaledW + BitsPerStage - 1) / BitsPerStage;
    localparam int BinW         = DabStages * BitsPerStage;
    localparam int BcdW         = 4 * DigitCount;
    localparam int SegIdxW      = $clog2(WordW);
    localparam int SegCodeW     = 7;

    // Queue between the front and the back.
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Segment word indexes that carry the sign and the dots.
    localparam int ComSign = 2;
    localparam int ComDot  = 3;

    // Command codes on the input channel.
    localparam logic [ModeW-1:0] ModeNumber = 3'd0;
    localparam logic [ModeW-1:0] ModeDigit  = 3'd1;
    localparam logic [ModeW-1:0] ModeDot    = 3'd2;
    localparam logic [ModeW-1:0] ModeSign   = 3'd3;
    localparam logic [ModeW-1:0] ModeClear  = 3'd4;

    // Operation kinds after classification.
    localparam int KindW = 3;
    localparam logic [KindW-1:0] OpNone  = 3'd0;
    localparam logic [KindW-1:0] OpNum   = 3'd1;
    localparam logic [KindW-1:0] OpDigit = 3'd2;
    localparam logic [KindW-1:0] OpDot   = 3'd3;
    localparam logic [KindW-1:0] OpSign  = 3'd4;
    localparam logic [KindW-1:0] OpClear = 3'd5;

    typedef logic [PowW-1:0] t_pow;
    typedef logic [ComCount-1:0][WordW-1:0] t_words;

    // Control fields that travel with an operation through the back pipeline.
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic             neg;
        logic             dot_en;
        logic [PosW-1:0]  dot_pos;
        logic [PosW-1:0]  pos;
        logic [DigW-1:0]  dig;
        logic             lit;
    } t_ctrl;

    // One classified operation as it sits in the queue.
    typedef struct packed {
        t_ctrl           ctrl;
        logic [MagW-1:0] mag;
        t_pow            pow;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_pow pow_ten(input logic [DecW-1:0] d);
        t_pow p;
        case (d)
            3'd0:    p = t_pow'(1);
            3'd1:    p = t_pow'(10);
            3'd2:    p = t_pow'(100);
            3'd3:    p = t_pow'(1000);
            3'd4:    p = t_pow'(10000);
            3'd5:    p = t_pow'(100000);
            3'd6:    p = t_pow'(1000000);
            3'd7:    p = t_pow'(10000000);
            default: p = t_pow'(1);
        endcase
        return p;
    endfunction

    // Packed as {COM3 bit, COM2 pair, COM1 pair, COM0 pair}.
    function automatic logic [SegCodeW-1:0] seg_code(input logic [DigW-1:0] d);
        logic [SegCodeW-1:0] c;
        case (d)
            4'd0:    c = {1'b1, 2'd3, 2'd2, 2'd3};
            4'd1:    c = {1'b0, 2'd2, 2'd2, 2'd0};
            4'd2:    c = {1'b1, 2'd1, 2'd3, 2'd2};
            4'd3:    c = {1'b1, 2'd2, 2'd3, 2'd2};
            4'd4:    c = {1'b0, 2'd2, 2'd3, 2'd1};
            4'd5:    c = {1'b1, 2'd2, 2'd1, 2'd3};
            4'd6:    c = {1'b1, 2'd3, 2'd1, 2'd3};
            4'd7:    c = {1'b0, 2'd2, 2'd2, 2'd2};
            4'd8:    c = {1'b1, 2'd3, 2'd3, 2'd3};
            4'd9:    c = {1'b1, 2'd2, 2'd3, 2'd3};
            default: c = '0;
        endcase
        return c;
    endfunction

    // One shift-and-add-3 step. The carry out of the top digit is dropped, so the
    // BCD register keeps the value modulo ten to the DigitCount.
    function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                    input logic b);
        logic [BcdW-1:0] adj;
        adj = bcd;
        for (int k = 0; k < DigitCount; k++) begin
            if (adj[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BcdW-2:0], b};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/slnw_in_if.sv
`default_nettype none

interface slnw_in_if;
    logic                                valid;
    logic                                ready;
    logic [slnw_pkg::ModeW-1:0]          mode;
    logic signed [slnw_pkg::ValueW-1:0]  value;
    logic [slnw_pkg::DecW-1:0]           decimals;
    logic [slnw_pkg::PosW-1:0]           position;
    logic [slnw_pkg::DigW-1:0]           digit_value;
    logic                                on;

    modport source (output valid, mode, value, decimals, position, digit_value, on,
                    input ready);
    modport sink (input valid, mode, value, decimals, position, digit_value, on,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/slnw_out_if.sv
`default_nettype none

interface slnw_out_if;
    logic                        valid;
    logic                        ready;
    logic [slnw_pkg::WordW-1:0]  com0_word;
    logic [slnw_pkg::WordW-1:0]  com1_word;
    logic [slnw_pkg::WordW-1:0]  com2_word;
    logic [slnw_pkg::WordW-1:0]  com3_word;
    logic                        refresh_request;

    modport source (output valid, com0_word, com1_word, com2_word, com3_word,
                    refresh_request, input ready);
    modport sink (input valid, com0_word, com1_word, com2_word, com3_word,
                  refresh_request, output ready);
endinterface

`default_nettype wire

FILE: rtl/slnw_front.sv
`default_nettype none

module slnw_front (
    slnw_in_if.sink            i_item,
    input  slnw_pkg::t_q_stat  i_stat,
    output logic               o_push,
    output slnw_pkg::t_op      o_op
);

    logic [slnw_pkg::MagW-1:0] w_raw;
    logic                      w_neg;

    assign i_item.ready = !i_stat.full;
    assign o_push       = i_item.valid && !i_stat.full;

    assign w_raw = i_item.value;
    assign w_neg = w_raw[slnw_pkg::MagW-1];

    always_comb begin
        o_op              = '0;
        o_op.ctrl.neg     = w_neg;
        o_op.ctrl.pos     = i_item.position;
        o_op.ctrl.dig     = i_item.digit_value;
        o_op.ctrl.lit     = i_item.on;
        o_op.ctrl.dot_pos = slnw_pkg::PosW'(slnw_pkg::DigitCount - 1) - i_item.decimals;
        o_op.ctrl.dot_en  = (i_item.decimals != '0)
                            && ({1'b0, i_item.decimals}
                                < (slnw_pkg::DecW + 1)'(slnw_pkg::DigitCount));
        o_op.mag          = w_neg ? (slnw_pkg::MagW'(0) - w_raw) : w_raw;
        o_op.pow          = slnw_pkg::pow_ten(i_item.decimals);

        case (i_item.mode)
            slnw_pkg::ModeNumber: begin
                o_op.ctrl.kind = slnw_pkg::OpNum;
            end
            slnw_pkg::ModeDigit: begin
                // Digits above nine or positions off the glass leave the words alone.
                if ((i_item.digit_value <= slnw_pkg::DigW'(9))
                    && ({1'b0, i_item.position}
                        < (slnw_pkg::PosW + 1)'(slnw_pkg::DigitCount))) begin
                    o_op.ctrl.kind = slnw_pkg::OpDigit;
                end else begin
                    o_op.ctrl.kind = slnw_pkg::OpNone;
                end
            end
            slnw_pkg::ModeDot: begin
                if ({1'b0, i_item.position} < (slnw_pkg::PosW + 1)'(slnw_pkg::DotCount)) begin
                    o_op.ctrl.kind = slnw_pkg::OpDot;
                end else begin
                    o_op.ctrl.kind = slnw_pkg::OpNone;
                end
            end
            slnw_pkg::ModeSign: begin
                o_op.ctrl.kind = slnw_pkg::OpSign;
            end
            slnw_pkg::ModeClear: begin
                o_op.ctrl.kind = slnw_pkg::OpClear;
            end
            default: begin
                o_op.ctrl.kind = slnw_pkg::OpNone;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/slnw_queue.sv
`default_nettype none

module slnw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slnw_pkg::t_op      i_data,
    input  logic               i_pop,
    output slnw_pkg::t_op      o_data,
    output slnw_pkg::t_q_stat  o_stat
);

    slnw_pkg::t_op                r_mem [slnw_pkg::QueueDepth];
    logic [slnw_pkg::QPtrW-1:0]   r_wr;
    logic [slnw_pkg::QPtrW-1:0]   r_rd;
    logic [slnw_pkg::QCntW-1:0]   r_cnt;
    logic                         w_pop;

    function automatic logic [slnw_pkg::QPtrW-1:0] ptr_next(
        input logic [slnw_pkg::QPtrW-1:0] p);
        logic [slnw_pkg::QPtrW-1:0] n;
        if (p == slnw_pkg::QPtrW'(slnw_pkg::QueueDepth - 1)) begin
            n = '0;
        end else begin
            n = p + slnw_pkg::QPtrW'(1);
        end
        return n;
    endfunction

    assign o_stat.full  = (r_cnt == slnw_pkg::QCntW'(slnw_pkg::QueueDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (w_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + slnw_pkg::QCntW'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - slnw_pkg::QCntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/slnw_back.sv
`default_nettype none

module slnw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slnw_pkg::t_op      i_head,
    input  slnw_pkg::t_q_stat  i_stat,
    output logic               o_pop,
    slnw_out_if.source         o_result
);

    localparam int Last = slnw_pkg::DabStages - 1;

    logic w_adv;

    // Stage 1: two partial products of the magnitude.
    logic                                           r_s1_valid;
    slnw_pkg::t_ctrl                                r_s1_ctrl;
    logic [slnw_pkg::LoW+slnw_pkg::PowW-1:0]        r_s1_plo;
    logic [slnw_pkg::HiW+slnw_pkg::PowW-1:0]        r_s1_phi;

    // Stage 2: rounded, scaled binary value.
    logic                                           r_s2_valid;
    slnw_pkg::t_ctrl                                r_s2_ctrl;
    logic [slnw_pkg::BinW-1:0]                      r_s2_bin;
    logic [slnw_pkg::ProdW-1:0]                     w_sum;

    // Binary to BCD stages.
    logic [slnw_pkg::DabStages-1:0]                 r_d_valid;
    slnw_pkg::t_ctrl                                r_d_ctrl [slnw_pkg::DabStages];
    logic [slnw_pkg::BcdW-1:0]                      r_d_bcd  [slnw_pkg::DabStages];
    logic [slnw_pkg::BinW-1:0]                      r_d_bin  [slnw_pkg::DabStages];
    logic [slnw_pkg::BcdW-1:0]                      n_d_bcd  [slnw_pkg::DabStages];
    logic [slnw_pkg::BinW-1:0]                      n_d_bin  [slnw_pkg::DabStages];

    // Display state, which is also the result payload.
    logic                                           r_out_valid;
    logic                                           r_refresh;
    slnw_pkg::t_words                               r_words;
    slnw_pkg::t_words                               n_words;
    slnw_pkg::t_ctrl                                w_ctrl;
    logic [slnw_pkg::BcdW-1:0]                      w_bcd;

    function automatic slnw_pkg::t_words put_digit(
        input slnw_pkg::t_words          w,
        input logic [slnw_pkg::PosW-1:0] pos,
        input logic [slnw_pkg::DigW-1:0] dig);
        logic [slnw_pkg::SegIdxW-1:0]  s;
        logic [slnw_pkg::SegCodeW-1:0] code;
        slnw_pkg::t_words              r;
        r    = w;
        s    = slnw_pkg::SegIdxW'({pos, 1'b0}) + slnw_pkg::SegIdxW'(1);
        code = slnw_pkg::seg_code(dig);
        r[0][s +: 2] = code[1:0];
        r[1][s +: 2] = code[3:2];
        r[2][s +: 2] = code[5:4];
        r[3][s]      = code[6];
        return r;
    endfunction

    function automatic logic [slnw_pkg::SegIdxW-1:0] dot_index(
        input logic [slnw_pkg::PosW-1:0] pos);
        return slnw_pkg::SegIdxW'({pos, 1'b0}) + slnw_pkg::SegIdxW'(2);
    endfunction

    // The whole pipeline moves together; it holds only while a result waits.
    assign w_adv = !r_out_valid || o_result.ready;
    assign o_pop = w_adv && !i_stat.empty;

    assign w_sum = slnw_pkg::ProdW'(r_s1_plo)
                   + (slnw_pkg::ProdW'(r_s1_phi) << slnw_pkg::LoW)
                   + (slnw_pkg::ProdW'(1) << (slnw_pkg::FracBits - 1));

    always_comb begin
        logic [slnw_pkg::BcdW-1:0] bcd;
        logic [slnw_pkg::BinW-1:0] bin;
        for (int k = 0; k < slnw_pkg::DabStages; k++) begin
            if (k == 0) begin
                bcd = '0;
                bin = r_s2_bin;
            end else begin
                bcd = r_d_bcd[k-1];
                bin = r_d_bin[k-1];
            end
            for (int j = 0; j < slnw_pkg::BitsPerStage; j++) begin
                bcd = slnw_pkg::dabble_step(bcd, bin[slnw_pkg::BinW-1]);
                bin = bin << 1;
            end
            n_d_bcd[k] = bcd;
            n_d_bin[k] = bin;
        end
    end

    assign w_ctrl = r_d_ctrl[Last];
    assign w_bcd  = r_d_bcd[Last];

    always_comb begin
        n_words = r_words;
        case (w_ctrl.kind)
            slnw_pkg::OpNum: begin
                for (int p = 0; p < slnw_pkg::DigitCount; p++) begin
                    n_words = put_digit(n_words, slnw_pkg::PosW'(p),
                                        w_bcd[4*(slnw_pkg::DigitCount-1-p) +: 4]);
                end
                for (int p = 0; p < slnw_pkg::DotCount; p++) begin
                    n_words[slnw_pkg::ComDot][dot_index(slnw_pkg::PosW'(p))] = 1'b0;
                end
                if (w_ctrl.dot_en) begin
                    n_words[slnw_pkg::ComDot][dot_index(w_ctrl.dot_pos)] = 1'b1;
                end
                n_words[slnw_pkg::ComSign][0] = w_ctrl.neg;
            end
            slnw_pkg::OpDigit: begin
                n_words = put_digit(r_words, w_ctrl.pos, w_ctrl.dig);
            end
            slnw_pkg::OpDot: begin
                n_words[slnw_pkg::ComDot][dot_index(w_ctrl.pos)] = w_ctrl.lit;
            end
            slnw_pkg::OpSign: begin
                n_words[slnw_pkg::ComSign][0] = w_ctrl.lit;
            end
            slnw_pkg::OpClear: begin
                n_words = '0;
            end
            default: begin
                n_words = r_words;
            end
        endcase
    end

    // Control and display state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_d_valid   <= '0;
            r_out_valid <= 1'b0;
            r_refresh   <= 1'b0;
            r_words     <= '0;
        end else if (w_adv) begin
            r_s1_valid  <= !i_stat.empty;
            r_s2_valid  <= r_s1_valid;
            r_d_valid   <= {r_d_valid[slnw_pkg::DabStages-2:0], r_s2_valid};
            r_out_valid <= r_d_valid[Last];
            if (r_d_valid[Last]) begin
                r_words   <= n_words;
                r_refresh <= (w_ctrl.kind == slnw_pkg::OpNum);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ctrl <= i_head.ctrl;
            r_s1_plo  <= i_head.mag[slnw_pkg::LoW-1:0] * i_head.pow;
            r_s1_phi  <= i_head.mag[slnw_pkg::MagW-1:slnw_pkg::LoW] * i_head.pow;
            r_s2_ctrl <= r_s1_ctrl;
            r_s2_bin  <= slnw_pkg::BinW'(w_sum >> slnw_pkg::FracBits);
            for (int k = 0; k < slnw_pkg::DabStages; k++) begin
                r_d_ctrl[k] <= (k == 0) ? r_s2_ctrl : r_d_ctrl[k-1];
                r_d_bcd[k]  <= n_d_bcd[k];
                r_d_bin[k]  <= n_d_bin[k];
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.com0_word       = r_words[0];
    assign o_result.com1_word       = r_words[1];
    assign o_result.com2_word       = r_words[2];
    assign o_result.com3_word       = r_words[3];
    assign o_result.refresh_request = r_refresh;

endmodule

`default_nettype wire

FILE: rtl/segment_lcd_number_writer.sv
`default_nettype none

// Channel    Direction  Payload
// i_item     in         mode, value, decimals, position, digit_value, on
// o_result   out        com0_word .. com3_word, refresh_request
//
// Every transaction is accepted at one per cycle while the queue is not full and
// produces exactly one result. A result passes through the two-entry queue, one
// multiply stage, one round-and-scale stage, six binary-to-BCD stages of eight
// bits each, and the output register that also holds the segment words.
// Reset clears the segment words and all valid flags.
// A stalled result freezes the back pipeline; the front keeps taking transactions
// until the queue is full.

module segment_lcd_number_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slnw_in_if.sink     i_item,
    slnw_out_if.source  o_result
);

    // The front classifies each command and works out the magnitude and the
    // power of ten for number writes, so the back only sees ready-made operations.
    slnw_pkg::t_op      w_op;
    slnw_pkg::t_op      w_head;
    slnw_pkg::t_q_stat  w_stat;
    logic               w_push;
    logic               w_pop;

    slnw_front u_front (
        .i_item (i_item),
        .i_stat (w_stat),
        .o_push (w_push),
        .o_op   (w_op)
    );

    // The queue lets the front keep accepting while the back waits on the sink.
    slnw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_op),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_stat)
    );

    // The back scales, rounds, converts to decimal digits and edits the words.
    slnw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
